// File: src/gdbl_pkg.sv
package gdbl_pkg;

    // Fixed field widths of the register file.
    localparam int COEF_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A1   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A2   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ABS_LIMIT = 3'd5;

    // Reset values of the registers.
    localparam logic [COEF_W-1:0]  RST_COEF_B0   = 16'h4000;
    localparam logic [COEF_W-1:0]  RST_COEF_B1   = 16'h0000;
    localparam logic [COEF_W-1:0]  RST_COEF_B2   = 16'h0000;
    localparam logic [COEF_W-1:0]  RST_COEF_A1   = 16'h0000;
    localparam logic [COEF_W-1:0]  RST_COEF_A2   = 16'h0000;
    localparam logic [LIMIT_W-1:0] RST_ABS_LIMIT = 15'h7FFF;

    // Coefficient set shared by both lanes, signed Q2.14.
    typedef struct packed {
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
    } coef_set_t;

endpackage

// File: src/gdbl_sample_if.sv
interface gdbl_sample_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] accel_x;
    logic signed [W-1:0] accel_y;

    modport source (output valid, output accel_x, output accel_y, input ready);
    modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

// File: src/gdbl_result_if.sv
interface gdbl_result_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] filtered_x;
    logic signed [W-1:0] filtered_y;
    logic                sample_ok;

    modport source (output valid, output filtered_x, output filtered_y, output sample_ok,
                    input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input sample_ok,
                    output ready);
endinterface

// File: src/gdbl_cfg_if.sv
interface gdbl_cfg_if
    import gdbl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: src/gdbl_lane.sv
module gdbl_lane
    import gdbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  coef_set_t                      coefs,
    input  logic [LIMIT_W-1:0]             abs_limit,
    input  logic                           commit,
    output logic                           in_range,
    output logic signed [SAMPLE_WIDTH-1:0] filtered
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int SUM_A  = PROD_W + 3;
    localparam int SUM_W  = (SUM_A > COEF_FRAC_BITS + 2) ? SUM_A : COEF_FRAC_BITS + 2;
    localparam int MAG_A  = SAMPLE_WIDTH + 1;
    localparam int CMP_W  = (MAG_A > LIMIT_W) ? MAG_A : LIMIT_W;

    logic signed [SAMPLE_WIDTH-1:0] x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [SUM_W-1:0]  sum, biased, rounded;
    logic [SUM_W-SAMPLE_WIDTH:0] top_bits;
    logic                     fits;
    logic signed [MAG_A-1:0]  wide_sample;
    logic [CMP_W-1:0]         mag, lim;

    // Range gate: magnitude of the sample against the limit, equal passes.
    assign wide_sample = MAG_A'(sample);
    assign mag         = CMP_W'(wide_sample[MAG_A-1] ? -wide_sample : wide_sample);
    assign lim         = CMP_W'(abs_limit);
    assign in_range    = (mag <= lim);

    // Direct form I section.
    assign p_b0 = $signed(coefs.b0) * sample;
    assign p_b1 = $signed(coefs.b1) * x1_reg;
    assign p_b2 = $signed(coefs.b2) * x2_reg;
    assign p_a1 = $signed(coefs.a1) * y1_reg;
    assign p_a2 = $signed(coefs.a2) * y2_reg;

    assign sum = SUM_W'(p_b0) + SUM_W'(p_b1) + SUM_W'(p_b2)
               - SUM_W'(p_a1) - SUM_W'(p_a2);

    // Round half up, then clamp to the sample range.
    assign biased   = sum + (SUM_W'(1) << (COEF_FRAC_BITS - 1));
    assign rounded  = biased >>> COEF_FRAC_BITS;
    assign top_bits = rounded[SUM_W-1:SAMPLE_WIDTH-1];
    assign fits     = (&top_bits) | ~(|top_bits);

    always_comb
    begin
        if (fits)
        begin
            filtered = rounded[SAMPLE_WIDTH-1:0];
        end
        else if (rounded[SUM_W-1])
        begin
            filtered = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            filtered = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    // Advance history only on an accepted, in-range sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (commit)
        begin
            x2_reg <= x1_reg;
            x1_reg <= sample;
            y2_reg <= y1_reg;
            y1_reg <= filtered;
        end
    end

endmodule

// File: src/gdbl_merge.sv
module gdbl_merge
    import gdbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_range_x,
    input  logic                           in_range_y,
    input  logic signed [SAMPLE_WIDTH-1:0] value_x,
    input  logic signed [SAMPLE_WIDTH-1:0] value_y,
    output logic                           commit,
    gdbl_result_if.source                  result_out
);

    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] fx_reg, fy_reg;
    logic                           ok_reg;
    logic                           beat, ok;

    // Take a new beat whenever the output register is empty or drains now.
    assign in_ready       = !out_valid_reg || result_out.ready;
    assign beat           = in_valid && in_ready;
    assign ok             = in_range_x && in_range_y;
    assign commit         = beat && ok;
    assign out_valid_next = in_ready ? in_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Rejected samples report zero on both axes.
    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            fx_reg <= ok ? value_x : '0;
            fy_reg <= ok ? value_y : '0;
            ok_reg <= ok;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.filtered_x = fx_reg;
    assign result_out.filtered_y = fy_reg;
    assign result_out.sample_ok  = ok_reg;

endmodule

// File: src/gated_dual_axis_biquad_lowpass.sv
// Gated dual-axis biquad low-pass filter.
//
// Channels:
//   sample_in  - one beat carries an X and a Y acceleration sample.
//   result_out - one beat per input beat: filtered X, filtered Y, sample_ok.
//   cfg        - register writes (b0, b1, b2, a1, a2 in Q2.14, abs_limit);
//                always ready, out-of-range indexes are dropped. Write only
//                while no beat is in flight.
// Each axis runs in its own lane (a direct form I second-order section).
// The merge stage ANDs the lanes' range checks: if either axis magnitude
// exceeds abs_limit the beat is rejected, both outputs read zero and no
// filter history moves.
// Output: the result beat is registered and appears in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the output register can drain; the feedback
// path through the five multipliers, adder, rounding and clamp of a lane is combinational.
// Stall: the single output register holds its beat; sample_in.ready drops
// only while that register is full and result_out.ready is low.
// Reset: clears the filter history and output valid, and loads the
// coefficients with a pass-through (b0 = 1.0) and the limit with full scale.
module gated_dual_axis_biquad_lowpass
    import gdbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    gdbl_sample_if.sink   sample_in,
    gdbl_result_if.source result_out,
    gdbl_cfg_if.sink      cfg
);

    coef_set_t          coefs_reg;
    logic [LIMIT_W-1:0] abs_limit_reg;

    logic                           in_range_x, in_range_y;
    logic signed [SAMPLE_WIDTH-1:0] value_x, value_y;
    logic                           commit;
    logic                           in_ready;

    // Configuration: accept every write, hold the register file otherwise.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0  <= RST_COEF_B0;
            coefs_reg.b1  <= RST_COEF_B1;
            coefs_reg.b2  <= RST_COEF_B2;
            coefs_reg.a1  <= RST_COEF_A1;
            coefs_reg.a2  <= RST_COEF_A2;
            abs_limit_reg <= RST_ABS_LIMIT;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_COEF_B0:   coefs_reg.b0  <= cfg.wdata;
                REG_COEF_B1:   coefs_reg.b1  <= cfg.wdata;
                REG_COEF_B2:   coefs_reg.b2  <= cfg.wdata;
                REG_COEF_A1:   coefs_reg.a1  <= cfg.wdata;
                REG_COEF_A2:   coefs_reg.a2  <= cfg.wdata;
                REG_ABS_LIMIT: abs_limit_reg <= cfg.wdata[LIMIT_W-1:0];
                default:       ;
            endcase
        end
    end

    // X lane.
    gdbl_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_in.accel_x),
        .coefs     (coefs_reg),
        .abs_limit (abs_limit_reg),
        .commit    (commit),
        .in_range  (in_range_x),
        .filtered  (value_x)
    );

    // Y lane.
    gdbl_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_in.accel_y),
        .coefs     (coefs_reg),
        .abs_limit (abs_limit_reg),
        .commit    (commit),
        .in_range  (in_range_y),
        .filtered  (value_y)
    );

    // Merge the lanes' gate decisions and register the result beat.
    gdbl_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_in.valid),
        .in_ready   (in_ready),
        .in_range_x (in_range_x),
        .in_range_y (in_range_y),
        .value_x    (value_x),
        .value_y    (value_y),
        .commit     (commit),
        .result_out (result_out)
    );

    assign sample_in.ready = in_ready;

endmodule

// File: src/gdbl_checker.sv
module gdbl_checker
    import gdbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] filtered_x,
    input logic [SAMPLE_WIDTH-1:0] filtered_y,
    input logic                    sample_ok
);

    // No result beat is shown while reset is applied.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A taken input beat shows up as a result beat in the next cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("result beat missing one cycle after input beat");

    // An empty output stage never stalls the input.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // A rejected sample reads zero on both axes.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sample_ok) |-> (filtered_x == '0 && filtered_y == '0))
        else $error("rejected sample carries nonzero data");

    // A stalled result beat holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(filtered_x) && $stable(filtered_y) && $stable(sample_ok)))
        else $error("stalled result beat changed");

endmodule

bind gated_dual_axis_biquad_lowpass gdbl_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gdbl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_in.valid),
    .in_ready   (sample_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .filtered_x (result_out.filtered_x),
    .filtered_y (result_out.filtered_y),
    .sample_ok  (result_out.sample_ok)
);
